FILE: hw/rtl/mse_pkg.sv
// Shared types and constants for the MIPS subset executor.
// Holds the field widths, opcode and funct codes and the structs passed between modules.
// No dependencies.
`default_nettype none

package mse_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned REG_AW    = 5;
  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned MEM_AW    = 7;
  localparam int unsigned MEM_WORDS = 128;

  typedef logic [XLEN-1:0]   word_t;
  typedef logic [REG_AW-1:0] reg_idx_t;
  typedef logic [MEM_AW-1:0] mem_idx_t;
  typedef logic [5:0]        opcode_t;

  // Primary opcodes.
  localparam opcode_t OP_RTYPE = 6'd0;
  localparam opcode_t OP_J     = 6'd2;
  localparam opcode_t OP_BEQ   = 6'd4;
  localparam opcode_t OP_BNE   = 6'd5;
  localparam opcode_t OP_ADDI  = 6'd8;
  localparam opcode_t OP_SLTI  = 6'd10;
  localparam opcode_t OP_LW    = 6'd35;
  localparam opcode_t OP_SW    = 6'd43;

  // Function codes of the R-type group.
  localparam opcode_t FN_ADD = 6'd32;
  localparam opcode_t FN_SUB = 6'd34;
  localparam opcode_t FN_AND = 6'd36;
  localparam opcode_t FN_OR  = 6'd37;
  localparam opcode_t FN_SLT = 6'd42;

  typedef struct packed {
    word_t    next_pc;
    logic     reg_write;
    reg_idx_t dest_reg;
    word_t    write_data;
    logic     branch_taken;
    logic     mem_write;
    mem_idx_t mem_index;
    logic     unknown_op;
  } result_t;

  typedef struct packed {
    logic     we;
    reg_idx_t addr;
    word_t    data;
  } rf_wr_t;

  typedef struct packed {
    logic     rd_en;
    logic     wr_en;
    mem_idx_t addr;
    word_t    wdata;
  } dm_req_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mse_if.sv
// Valid/ready channel interfaces for the MIPS subset executor.
// Depends on mse_pkg for the payload types.
`default_nettype none

interface mse_in_if;
  logic          valid;
  logic          ready;
  mse_pkg::word_t instr;

  modport source (output valid, output instr, input ready);
  modport sink   (input valid, input instr, output ready);
endinterface

interface mse_out_if;
  logic                valid;
  logic                ready;
  mse_pkg::word_t      next_pc;
  logic                reg_write;
  mse_pkg::reg_idx_t   dest_reg;
  logic signed [31:0]  write_data;
  logic                branch_taken;
  logic                mem_write;
  mse_pkg::mem_idx_t   mem_index;
  logic                unknown_op;

  modport source (output valid, output next_pc, output reg_write, output dest_reg,
                  output write_data, output branch_taken, output mem_write,
                  output mem_index, output unknown_op, input ready);
  modport sink   (input valid, input next_pc, input reg_write, input dest_reg,
                  input write_data, input branch_taken, input mem_write,
                  input mem_index, input unknown_op, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mse_regfile.sv
// Register file: two registered read ports, one write port, per-entry valid bits.
// Depends on mse_pkg.
`default_nettype none

module mse_regfile (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire mse_pkg::reg_idx_t rs_addr,
  input  wire mse_pkg::reg_idx_t rt_addr,
  input  wire mse_pkg::rf_wr_t   wr,
  output mse_pkg::word_t         rs_data,
  output mse_pkg::word_t         rt_data
);

  logic [mse_pkg::XLEN-1:0]      mem [mse_pkg::REG_COUNT];
  logic [mse_pkg::REG_COUNT-1:0] vld_r;
  mse_pkg::word_t                rs_q_r;
  mse_pkg::word_t                rt_q_r;
  logic                          rs_v_r;
  logic                          rt_v_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rs_q_r <= mem[rs_addr];
      rt_q_r <= mem[rt_addr];
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rs_v_r <= 1'b0;
      rt_v_r <= 1'b0;
    end else begin
      if (wr.we) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rs_v_r <= vld_r[rs_addr];
        rt_v_r <= vld_r[rt_addr];
      end
    end
  end

  assign rs_data = rs_v_r ? rs_q_r : '0;
  assign rt_data = rt_v_r ? rt_q_r : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/mse_datamem.sv
// Data memory: one write and one registered read per cycle, per-word valid bits.
// Depends on mse_pkg.
`default_nettype none

module mse_datamem (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mse_pkg::dm_req_t req,
  output mse_pkg::word_t        rdata
);

  logic [mse_pkg::XLEN-1:0]      mem [mse_pkg::MEM_WORDS];
  logic [mse_pkg::MEM_WORDS-1:0] vld_r;
  mse_pkg::word_t                q_r;
  logic                          qv_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      q_r <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        qv_r <= vld_r[req.addr];
      end
    end
  end

  assign rdata = qv_r ? q_r : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/mse_exec.sv
// Decode and execute logic for one instruction: ALU, compares, address and PC update.
// Depends on mse_pkg. Purely combinational.
`default_nettype none

module mse_exec (
  input  wire mse_pkg::word_t  instr,
  input  wire mse_pkg::word_t  op_a,
  input  wire mse_pkg::word_t  op_b,
  input  wire mse_pkg::word_t  pc,
  output mse_pkg::result_t     res,
  output logic                 is_load,
  output logic                 is_store
);

  mse_pkg::opcode_t  op;
  mse_pkg::opcode_t  fn;
  mse_pkg::reg_idx_t rt;
  mse_pkg::reg_idx_t rd;
  mse_pkg::word_t    simm;
  mse_pkg::word_t    addr_sum;
  mse_pkg::word_t    pc_base;
  logic              lt_ab;
  logic              lt_ai;
  logic              wr;

  assign op       = instr[31:26];
  assign fn       = instr[5:0];
  assign rt       = instr[20:16];
  assign rd       = instr[15:11];
  assign simm     = {{16{instr[15]}}, instr[15:0]};
  assign addr_sum = op_a + simm;
  assign lt_ab    = $signed(op_a) < $signed(op_b);
  assign lt_ai    = $signed(op_a) < $signed(simm);

  always_comb begin
    res      = '0;
    is_load  = 1'b0;
    is_store = 1'b0;
    wr       = 1'b0;
    pc_base  = pc;
    case (op)
      mse_pkg::OP_RTYPE: begin
        res.dest_reg = rd;
        wr           = 1'b1;
        case (fn)
          mse_pkg::FN_ADD: res.write_data = op_a + op_b;
          mse_pkg::FN_SUB: res.write_data = op_a - op_b;
          mse_pkg::FN_AND: res.write_data = op_a & op_b;
          mse_pkg::FN_OR:  res.write_data = op_a | op_b;
          mse_pkg::FN_SLT: res.write_data = {{(mse_pkg::XLEN-1){1'b0}}, lt_ab};
          default: begin
            wr             = 1'b0;
            res.dest_reg   = '0;
            res.unknown_op = 1'b1;
          end
        endcase
      end
      mse_pkg::OP_J: begin
        pc_base = {6'b0, instr[25:0]};
      end
      mse_pkg::OP_BEQ: res.branch_taken = (op_a == op_b);
      mse_pkg::OP_BNE: res.branch_taken = (op_a != op_b);
      mse_pkg::OP_ADDI: begin
        res.dest_reg   = rt;
        wr             = 1'b1;
        res.write_data = addr_sum;
      end
      mse_pkg::OP_SLTI: begin
        res.dest_reg   = rt;
        wr             = 1'b1;
        res.write_data = {{(mse_pkg::XLEN-1){1'b0}}, lt_ai};
      end
      mse_pkg::OP_LW: begin
        res.dest_reg  = rt;
        wr            = 1'b1;
        res.mem_index = addr_sum[mse_pkg::MEM_AW-1:0];
        is_load       = 1'b1;
      end
      mse_pkg::OP_SW: begin
        res.mem_index  = addr_sum[mse_pkg::MEM_AW-1:0];
        res.mem_write  = 1'b1;
        res.write_data = op_b;
        is_store       = 1'b1;
      end
      default: res.unknown_op = 1'b1;
    endcase
    // Writes to register zero are dropped but still report the target.
    res.reg_write = wr && (res.dest_reg != '0);
    res.next_pc   = pc_base + 1'b1;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mips_subset_executor_top.sv
// MIPS subset executor: three-stage pipeline from instruction word to result beat.
// Uses mse_pkg, mse_if, mse_regfile, mse_datamem and mse_exec.
//
// Usage:
//   in_bus carries one 32-bit instruction word per beat. out_bus returns one
//   result beat per instruction, in order: next PC, register write info, write
//   data, branch outcome, store flag, memory word index and an unknown-op flag.
//   Stage 1 holds the instruction with the registered register-file read; the
//   operands are forwarded from the two older write sources there, and the
//   instruction executes and updates the data memory and PC. Stage 2 holds the
//   registered data-memory read for loads and writes the register file. The
//   output register then offers the beat.
//   A beat accepted on in_bus passes the stage 1, stage 2 and output registers
//   before out_bus offers it; throughput is one instruction per clock while
//   the receiver keeps ready high. A stalled receiver holds the output beat;
//   the stages behind it keep filling any empty slot, so up to three beats sit
//   inside before in_bus ready drops.
//   Reset (synchronous, active low) clears the PC, all pipeline valid bits and
//   the valid bits of both memories, so all registers and memory words read
//   as zero afterwards; no clearing pass is needed.
`default_nettype none

module mips_subset_executor_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mse_in_if.sink     in_bus,
  mse_out_if.source  out_bus
);

  logic             s1_v_r;
  logic             s2_v_r;
  logic             out_v_r;
  logic             out_adv;
  logic             s2_adv;
  logic             s1_adv;
  logic             in_fire;
  logic             s1_move;
  logic             s2_move;

  mse_pkg::word_t   s1_instr_r;
  mse_pkg::rf_wr_t  s1_byp_r;
  mse_pkg::word_t   pc_r;
  mse_pkg::result_t s2_res_r;
  logic             s2_load_r;
  mse_pkg::result_t out_res_r;

  mse_pkg::word_t   rf_rs_data;
  mse_pkg::word_t   rf_rt_data;
  mse_pkg::rf_wr_t  rf_wr;
  mse_pkg::word_t   op_a;
  mse_pkg::word_t   op_b;
  mse_pkg::reg_idx_t s1_rs;
  mse_pkg::reg_idx_t s1_rt;
  mse_pkg::result_t ex_res;
  logic             ex_load;
  logic             ex_store;
  mse_pkg::dm_req_t dm_req;
  mse_pkg::word_t   dm_rdata;
  mse_pkg::word_t   s2_wdata;
  mse_pkg::result_t s2_final;

  assign out_adv  = !out_v_r || out_bus.ready;
  assign s2_adv   = !s2_v_r || out_adv;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_fire  = in_bus.valid && in_bus.ready;
  assign s1_move  = s1_v_r && s2_adv;
  assign s2_move  = s2_v_r && out_adv;
  assign in_bus.ready = s1_adv && rst_n;

  // Register file is written as the instruction leaves stage 2.
  assign s2_wdata    = s2_load_r ? dm_rdata : s2_res_r.write_data;
  assign rf_wr.we    = s2_move && s2_res_r.reg_write;
  assign rf_wr.addr  = s2_res_r.dest_reg;
  assign rf_wr.data  = s2_wdata;

  mse_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rs_addr (in_bus.instr[25:21]),
    .rt_addr (in_bus.instr[20:16]),
    .wr      (rf_wr),
    .rs_data (rf_rs_data),
    .rt_data (rf_rt_data)
  );

  // The read in stage 1 misses the write made at the same edge (kept in
  // s1_byp_r) and the one still pending in stage 2, which is the youngest.
  assign s1_rs = s1_instr_r[25:21];
  assign s1_rt = s1_instr_r[20:16];

  always_comb begin
    op_a = rf_rs_data;
    op_b = rf_rt_data;
    if (s1_byp_r.we && (s1_byp_r.addr == s1_rs)) begin
      op_a = s1_byp_r.data;
    end
    if (s1_byp_r.we && (s1_byp_r.addr == s1_rt)) begin
      op_b = s1_byp_r.data;
    end
    if (s2_v_r && s2_res_r.reg_write && (s2_res_r.dest_reg == s1_rs)) begin
      op_a = s2_wdata;
    end
    if (s2_v_r && s2_res_r.reg_write && (s2_res_r.dest_reg == s1_rt)) begin
      op_b = s2_wdata;
    end
  end

  mse_exec u_exec (
    .instr    (s1_instr_r),
    .op_a     (op_a),
    .op_b     (op_b),
    .pc       (pc_r),
    .res      (ex_res),
    .is_load  (ex_load),
    .is_store (ex_store)
  );

  assign dm_req.rd_en = s1_move;
  assign dm_req.wr_en = s1_move && ex_store;
  assign dm_req.addr  = ex_res.mem_index;
  assign dm_req.wdata = op_b;

  mse_datamem u_datamem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dm_req),
    .rdata (dm_rdata)
  );

  always_comb begin
    s2_final            = s2_res_r;
    s2_final.write_data = s2_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      pc_r        <= '0;
      s1_byp_r.we <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_r <= in_bus.valid;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
      end
      if (out_adv) begin
        out_v_r <= s2_v_r;
      end
      if (s1_move) begin
        pc_r <= ex_res.next_pc;
      end
      if (in_fire) begin
        s1_byp_r.we   <= rf_wr.we;
        s1_byp_r.addr <= rf_wr.addr;
        s1_byp_r.data <= rf_wr.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_instr_r <= in_bus.instr;
    end
    if (s1_move) begin
      s2_res_r  <= ex_res;
      s2_load_r <= ex_load;
    end
    if (s2_move) begin
      out_res_r <= s2_final;
    end
  end

  assign out_bus.valid        = out_v_r;
  assign out_bus.next_pc      = out_res_r.next_pc;
  assign out_bus.reg_write    = out_res_r.reg_write;
  assign out_bus.dest_reg     = out_res_r.dest_reg;
  assign out_bus.write_data   = signed'(out_res_r.write_data);
  assign out_bus.branch_taken = out_res_r.branch_taken;
  assign out_bus.mem_write    = out_res_r.mem_write;
  assign out_bus.mem_index    = out_res_r.mem_index;
  assign out_bus.unknown_op   = out_res_r.unknown_op;

endmodule

`default_nettype wire

FILE: sim/mips_subset_executor_top_tb.sv
// Self-checking testbench for mips_subset_executor_top.
// Depends on mse_pkg, mse_if and the executor RTL; a scoreboard class predicts each result beat.
`default_nettype none

module mips_subset_executor_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS  = 1200;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned LONG_HOLD_OFF = 150;
  localparam int unsigned DRAIN_CYCLES  = 10;

  class mse_scoreboard;
    mse_pkg::word_t   gpr [mse_pkg::REG_COUNT];
    mse_pkg::word_t   dmem [mse_pkg::MEM_WORDS];
    mse_pkg::word_t   pc;
    mse_pkg::result_t pending_results [$];
    int unsigned      fail_count;

    function new();
      foreach (gpr[i]) gpr[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      pc = '0;
      fail_count = 0;
    endfunction

    // Executes one accepted instruction on the shadow state and queues its result.
    function void predict_instr(mse_pkg::word_t instr);
      mse_pkg::opcode_t  op   = instr[31:26];
      mse_pkg::reg_idx_t rs   = instr[25:21];
      mse_pkg::reg_idx_t rt   = instr[20:16];
      mse_pkg::reg_idx_t rd   = instr[15:11];
      mse_pkg::opcode_t  fn   = instr[5:0];
      mse_pkg::word_t    simm = {{16{instr[15]}}, instr[15:0]};
      mse_pkg::word_t    a    = gpr[rs];
      mse_pkg::word_t    b    = gpr[rt];
      mse_pkg::word_t    addr;
      mse_pkg::result_t  r;
      r = '0;
      case (op)
        mse_pkg::OP_RTYPE: begin
          r.dest_reg  = rd;
          r.reg_write = 1'b1;
          case (fn)
            mse_pkg::FN_ADD: r.write_data = a + b;
            mse_pkg::FN_SUB: r.write_data = a - b;
            mse_pkg::FN_AND: r.write_data = a & b;
            mse_pkg::FN_OR:  r.write_data = a | b;
            mse_pkg::FN_SLT: r.write_data = {31'd0, $signed(a) < $signed(b)};
            default: begin
              r.reg_write  = 1'b0;
              r.dest_reg   = '0;
              r.unknown_op = 1'b1;
            end
          endcase
        end
        mse_pkg::OP_J:    pc = {6'd0, instr[25:0]};
        mse_pkg::OP_BEQ:  r.branch_taken = (a == b);
        mse_pkg::OP_BNE:  r.branch_taken = (a != b);
        mse_pkg::OP_ADDI: begin
          r.dest_reg   = rt;
          r.reg_write  = 1'b1;
          r.write_data = a + simm;
        end
        mse_pkg::OP_SLTI: begin
          r.dest_reg   = rt;
          r.reg_write  = 1'b1;
          r.write_data = {31'd0, $signed(a) < $signed(simm)};
        end
        mse_pkg::OP_LW: begin
          addr         = a + simm;
          r.mem_index  = addr[mse_pkg::MEM_AW-1:0];
          r.dest_reg   = rt;
          r.reg_write  = 1'b1;
          r.write_data = dmem[r.mem_index];
        end
        mse_pkg::OP_SW: begin
          addr         = a + simm;
          r.mem_index  = addr[mse_pkg::MEM_AW-1:0];
          r.mem_write  = 1'b1;
          r.write_data = b;
          dmem[r.mem_index] = b;
        end
        default: r.unknown_op = 1'b1;
      endcase
      // Register zero keeps its value; the beat still shows target and data.
      if (r.reg_write && r.dest_reg == '0) r.reg_write = 1'b0;
      if (r.reg_write) gpr[r.dest_reg] = r.write_data;
      pc = pc + 1;
      r.next_pc = pc;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, seen);
        fail_count++;
      end
    endfunction

    function void check_result(mse_pkg::result_t seen);
      mse_pkg::result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual next_pc %h",
                 $time, seen.next_pc);
        fail_count++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("next_pc", want.next_pc, seen.next_pc);
      compare_field("reg_write", 32'(want.reg_write), 32'(seen.reg_write));
      compare_field("dest_reg", 32'(want.dest_reg), 32'(seen.dest_reg));
      compare_field("write_data", want.write_data, seen.write_data);
      compare_field("branch_taken", 32'(want.branch_taken), 32'(seen.branch_taken));
      compare_field("mem_write", 32'(want.mem_write), 32'(seen.mem_write));
      compare_field("mem_index", 32'(want.mem_index), 32'(seen.mem_index));
      compare_field("unknown_op", 32'(want.unknown_op), 32'(seen.unknown_op));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  mse_in_if  in_bus ();
  mse_out_if out_bus ();

  mips_subset_executor_top u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  mse_scoreboard sb = new();

  int unsigned sent_count = 0;
  int unsigned burst_left = 0;
  bit          offering   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic mse_pkg::word_t enc_r(mse_pkg::opcode_t fn, mse_pkg::reg_idx_t rs,
                                           mse_pkg::reg_idx_t rt, mse_pkg::reg_idx_t rd,
                                           logic [4:0] shamt);
    return {mse_pkg::OP_RTYPE, rs, rt, rd, shamt, fn};
  endfunction

  function automatic mse_pkg::word_t enc_i(mse_pkg::opcode_t op, mse_pkg::reg_idx_t rs,
                                           mse_pkg::reg_idx_t rt, logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // Offers one instruction beat and waits for it to be taken; may end a burst with a gap.
  task automatic issue(input mse_pkg::word_t w);
    int unsigned gap;
    in_bus.valid <= 1'b1;
    in_bus.instr <= w;
    offering = 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    sent_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(30, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin : stimulus
    mse_pkg::opcode_t  alu_fn [5];
    int unsigned       sel;
    mse_pkg::reg_idx_t rs, rt, rd;
    logic [15:0]       imm;
    mse_pkg::word_t    w;
    alu_fn = '{mse_pkg::FN_ADD, mse_pkg::FN_SUB, mse_pkg::FN_AND, mse_pkg::FN_OR,
               mse_pkg::FN_SLT};
    rst_n        <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.instr <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // All-zero and all-ones words are both unsupported encodings.
    issue(32'h0000_0000);
    issue(32'hFFFF_FFFF);
    issue(enc_i(mse_pkg::OP_ADDI, 5'd0, 5'd1, 16'h7FFF));
    issue(enc_i(mse_pkg::OP_ADDI, 5'd0, 5'd2, 16'h8000));
    issue(enc_i(mse_pkg::OP_ADDI, 5'd1, 5'd0, 16'h0005));
    issue(enc_r(mse_pkg::FN_ADD, 5'd1, 5'd2, 5'd3, 5'd0));
    issue(enc_r(mse_pkg::FN_SUB, 5'd2, 5'd1, 5'd4, 5'd31));
    issue(enc_r(mse_pkg::FN_AND, 5'd3, 5'd1, 5'd5, 5'd0));
    issue(enc_r(mse_pkg::FN_OR, 5'd2, 5'd1, 5'd6, 5'd0));
    issue(enc_r(mse_pkg::FN_SLT, 5'd2, 5'd1, 5'd7, 5'd0));
    issue(enc_r(mse_pkg::FN_SLT, 5'd1, 5'd2, 5'd8, 5'd0));
    issue(enc_i(mse_pkg::OP_SLTI, 5'd2, 5'd9, 16'hFFFF));
    issue(enc_i(mse_pkg::OP_SLTI, 5'd1, 5'd10, 16'h8000));
    // Store offsets wrap the word index to the top of memory.
    issue(enc_i(mse_pkg::OP_SW, 5'd1, 5'd3, 16'h7FFF));
    issue(enc_i(mse_pkg::OP_SW, 5'd0, 5'd1, 16'hFFFF));
    issue(enc_i(mse_pkg::OP_LW, 5'd0, 5'd11, 16'hFFFF));
    issue(enc_i(mse_pkg::OP_LW, 5'd1, 5'd12, 16'h7FFF));
    issue(enc_i(mse_pkg::OP_LW, 5'd0, 5'd13, 16'h0000));
    issue(enc_i(mse_pkg::OP_BEQ, 5'd1, 5'd1, 16'h1234));
    issue(enc_i(mse_pkg::OP_BEQ, 5'd1, 5'd2, 16'h0000));
    issue(enc_i(mse_pkg::OP_BNE, 5'd1, 5'd2, 16'hFFFF));
    issue(enc_i(mse_pkg::OP_BNE, 5'd0, 5'd0, 16'h0001));
    issue({mse_pkg::OP_J, 26'h3FF_FFFF});
    issue({mse_pkg::OP_J, 26'h000_0000});
    issue(enc_r(6'h3F, 5'd1, 5'd2, 5'd3, 5'd0));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(99, 0);
      rs  = 5'($urandom_range(31, 0));
      rt  = 5'($urandom_range(31, 0));
      rd  = 5'($urandom_range(31, 0));
      imm = 16'($urandom_range(16'hFFFF, 0));
      if (sel < 35)
        w = enc_r(alu_fn[$urandom_range(4, 0)], rs, rt, rd, 5'($urandom));
      else if (sel < 50)
        w = enc_i(mse_pkg::OP_ADDI, rs, rt, imm);
      else if (sel < 55)
        w = enc_i(mse_pkg::OP_SLTI, rs, rt, imm);
      else if (sel < 70)
        w = enc_i(mse_pkg::OP_LW, ($urandom_range(1, 0) != 0) ? rs : 5'd0, rt, imm);
      else if (sel < 85)
        w = enc_i(mse_pkg::OP_SW, ($urandom_range(1, 0) != 0) ? rs : 5'd0, rt, imm);
      else if (sel < 93)
        w = enc_i(($urandom_range(1, 0) != 0) ? mse_pkg::OP_BEQ : mse_pkg::OP_BNE,
                  rs, rt, imm);
      else if (sel < 95)
        w = {mse_pkg::OP_J, 26'($urandom)};
      else if (sel < 97)
        w = enc_r(6'($urandom), rs, rt, rd, 5'($urandom));
      else
        w = $urandom;
      issue(w);
    end
    if (offering) in_bus.valid <= 1'b0;

    // Let the monitor queue the last accepted beat before waiting for the queue to drain.
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // The receiver switches between stall patterns and holds off once for a long stretch.
  initial begin : receiver
    int unsigned mode;
    int unsigned phase_left;
    bit          held_off;
    mode       = 0;
    phase_left = 0;
    held_off   = 1'b0;
    out_bus.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && sent_count >= 400) begin
        held_off = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD_OFF) @(posedge clk);
      end else begin
        if (phase_left == 0) begin
          mode       = $urandom_range(3, 0);
          phase_left = $urandom_range(200, 20);
        end
        phase_left--;
        case (mode)
          0:       out_bus.ready <= 1'b1;
          1:       out_bus.ready <= ($urandom_range(1, 0) != 0);
          2:       out_bus.ready <= ($urandom_range(7, 0) != 0);
          default: out_bus.ready <= ((phase_left % 5) >= 2);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : monitor
    mse_pkg::result_t seen;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        seen.next_pc      = out_bus.next_pc;
        seen.reg_write    = out_bus.reg_write;
        seen.dest_reg     = out_bus.dest_reg;
        seen.write_data   = out_bus.write_data;
        seen.branch_taken = out_bus.branch_taken;
        seen.mem_write    = out_bus.mem_write;
        seen.mem_index    = out_bus.mem_index;
        seen.unknown_op   = out_bus.unknown_op;
        sb.check_result(seen);
      end
      if (in_bus.valid && in_bus.ready) sb.predict_instr(in_bus.instr);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
